>>> rtl/core/itrd_pkg.sv
// shared constants, the digit to ascii mapping and the radix clamp for the radix digit converter
package itrd_pkg;

  localparam int unsigned DEF_VALUE_BITS = 31;
  localparam int unsigned DEF_MAX_DIGITS = 31;

  localparam int unsigned RADIX_W  = 6;
  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned STEP_BITS = 4;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] DEC_DIGITS  = 6'd10;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_A    = 7'd65;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_DIGITS) begin
      c = ASCII_ZERO + {1'b0, d};
    end else begin
      c = ASCII_A + {1'b0, d} - {1'b0, DEC_DIGITS};
    end
    return c;
  endfunction

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] v);
    logic [RADIX_W-1:0] r;
    if (v < RADIX_MIN) begin
      r = RADIX_MIN;
    end else if (v > RADIX_MAX) begin
      r = RADIX_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/itrd_div.sv
// iterative restoring divider, a few quotient bits per cycle, small divisor
module itrd_div
  import itrd_pkg::*;
#(
  parameter int unsigned VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [RADIX_W-1:0]    divisor_i,
  output logic                  done_o,
  output logic [VALUE_BITS-1:0] quot_o,
  output logic [RADIX_W-1:0]    rem_o
);

  localparam int unsigned Steps = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int unsigned PadW  = Steps * STEP_BITS;
  localparam int unsigned CntW  = $clog2(Steps + 1);

  logic [PadW-1:0]    work_q, work_d;
  logic [RADIX_W-1:0] rem_q, rem_d;
  logic [RADIX_W-1:0] dvs_q;
  logic [CntW-1:0]    cnt_q;
  logic               done_q;

  // quotient bits shift in at the bottom as the dividend shifts out at the top
  always_comb begin
    logic [RADIX_W:0] r;
    logic [PadW-1:0]  w;
    r = {1'b0, rem_q};
    w = work_q;
    for (int i = 0; i < STEP_BITS; i++) begin
      r = {r[RADIX_W-1:0], w[PadW-1]};
      w = {w[PadW-2:0], 1'b0};
      if (r >= {1'b0, dvs_q}) begin
        r    = r - {1'b0, dvs_q};
        w[0] = 1'b1;
      end
    end
    work_d = w;
    rem_d  = r[RADIX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CntW'(Steps);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= PadW'(dividend_i);
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (cnt_q != '0) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = work_q[VALUE_BITS-1:0];
  assign rem_o  = rem_q;

endmodule

>>> rtl/core/itrd_stack.sv
// digit store, one write and one registered read per cycle
module itrd_stack
  import itrd_pkg::*;
#(
  parameter int unsigned DEPTH = DEF_MAX_DIGITS
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [RADIX_W-1:0]       wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [RADIX_W-1:0]       rd_data_o
);

  logic [RADIX_W-1:0] mem [DEPTH];
  logic [RADIX_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/core/integer_to_radix_digits.sv
// top level: converts an integer into ascii digits in a configured radix
// all digits are first produced by the shared divider (four quotient bits per cycle), then each word
//   is emitted through the S_RD and S_OUT states
// throughput: one number at a time, busy_o is high from start until the last word is issued
// results appear one word per strobe on valid_o, the receiver cannot stall them
// reset: asynchronous, active low; radix returns to ten, sequencer to idle, no clearing pass
module integer_to_radix_digits
  import itrd_pkg::*;
#(
  parameter int unsigned VALUE_BITS = DEF_VALUE_BITS,
  parameter int unsigned MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  cfg_we_i,
  input  logic [RADIX_W-1:0]    cfg_wdata_i,
  output logic                  valid_o,
  output logic [CHAR_W-1:0]     digit_char_o,
  output logic                  last_o
);

  localparam int unsigned AddrW = $clog2(MAX_DIGITS);
  localparam int unsigned CntW  = $clog2(MAX_DIGITS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_RD,
    S_OUT
  } state_e;

  state_e             state_q;
  logic [RADIX_W-1:0] radix_q;
  logic [VALUE_BITS-1:0] x_q;
  logic [CntW-1:0]    cnt_q;
  logic [AddrW-1:0]   rd_ptr_q;
  logic               div_start_q;
  logic               valid_q;
  logic               last_q;
  logic [CHAR_W-1:0]  char_q;

  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [RADIX_W-1:0]    div_rem;
  logic [RADIX_W-1:0]    rd_digit;
  logic                  wr_en;

  itrd_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk_i,
    .rst_ni,
    .start_i   (div_start_q),
    .dividend_i(x_q),
    .divisor_i (radix_q),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  assign wr_en = (state_q == S_DIV) && div_done;

  itrd_stack #(
    .DEPTH(MAX_DIGITS)
  ) u_stack (
    .clk_i,
    .wr_en_i  (wr_en),
    .wr_addr_i(cnt_q[AddrW-1:0]),
    .wr_data_i(div_rem),
    .rd_addr_i(rd_ptr_q),
    .rd_data_o(rd_digit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (cfg_we_i) begin
      radix_q <= clamp_radix(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rd_ptr_q    <= '0;
      div_start_q <= 1'b0;
      valid_q     <= 1'b0;
      last_q      <= 1'b0;
      char_q      <= ASCII_ZERO;
      x_q         <= '0;
    end else begin
      div_start_q <= 1'b0;
      valid_q     <= 1'b0;
      last_q      <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            x_q         <= value_i;
            cnt_q       <= '0;
            div_start_q <= 1'b1;
            state_q     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            x_q   <= div_quot;
            cnt_q <= cnt_q + 1'b1;
            // digits beyond the store would never be emitted, so stop there
            if (div_quot == '0 || cnt_q == CntW'(MAX_DIGITS - 1)) begin
              rd_ptr_q <= cnt_q[AddrW-1:0];
              state_q  <= S_RD;
            end else begin
              div_start_q <= 1'b1;
            end
          end
        end
        S_RD: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          valid_q <= 1'b1;
          char_q  <= digit_to_ascii(rd_digit);
          if (rd_ptr_q == '0) begin
            last_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            rd_ptr_q <= rd_ptr_q - 1'b1;
            state_q  <= S_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o       = (state_q != S_IDLE);
  assign valid_o      = valid_q;
  assign digit_char_o = char_q;
  assign last_o       = last_q;

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((digit_char_o >= 7'd48 && digit_char_o <= 7'd57) ||
                 (digit_char_o >= 7'd65 && digit_char_o <= 7'd90)))
    else $error("digit word outside the ascii digit set");

  a_last_has_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> valid_o)
    else $error("last flag without a word");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_DIGITS))
    else $error("digit count past the store depth");

  a_radix_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (radix_q >= RADIX_MIN) && (radix_q <= RADIX_MAX))
    else $error("radix register out of range");

  a_no_word_while_dividing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (!valid_o || last_o))
    else $error("digit word issued during division");

endmodule
